FILE: rtl/pbs_pkg.sv
`timescale 1ns / 1ps

package pbs_pkg;

	// Field widths fixed by the block's interface.
	localparam int CountW = 16;
	localparam int TickW  = 8;
	localparam int SpeedW = 4;
	localparam int ModeW  = 3;
	localparam int StepW  = TickW + SpeedW;

	// APB register map: register i sits at byte address 4*i.
	localparam int AddrW  = 5;
	localparam int DataW  = 32;
	localparam int RegIdxW = 3;

	typedef enum logic [RegIdxW-1:0] {
		REG_HOLD_TIME   = 3'd0,
		REG_GLITCH_TIME = 3'd1,
		REG_TICK_PERIOD = 3'd2,
		REG_SPEEDUP     = 3'd3,
		REG_BUTTON_LOCK = 3'd4
	} reg_idx_t;

	// Reset values of the registers and of the countdown.
	localparam logic [CountW-1:0] RstHoldTime   = 16'd500;
	localparam logic [CountW-1:0] RstGlitchTime = 16'd100;
	localparam logic [TickW-1:0]  RstTickPeriod = 8'd10;
	localparam logic [SpeedW-1:0] RstSpeedup    = 4'd4;

	// Mode codes as reported on the result channel.
	localparam logic [ModeW-1:0] MODE_UP_HOLD     = 3'd0;
	localparam logic [ModeW-1:0] MODE_UP_RELEASE  = 3'd1;
	localparam logic [ModeW-1:0] MODE_LED_BLINK   = 3'd2;
	localparam logic [ModeW-1:0] MODE_GOOD_HOLD   = 3'd3;
	localparam logic [ModeW-1:0] MODE_RUN_RELEASE = 3'd4;
	localparam logic [ModeW-1:0] MODE_RUN_HOLD    = 3'd5;

	// Sequencer state, one-hot.
	typedef enum logic [5:0] {
		ST_UP_HOLD     = 6'b000001,
		ST_UP_RELEASE  = 6'b000010,
		ST_LED_BLINK   = 6'b000100,
		ST_GOOD_HOLD   = 6'b001000,
		ST_RUN_RELEASE = 6'b010000,
		ST_RUN_HOLD    = 6'b100000
	} seq_state_t;

	// Configuration as seen by the sequencer core.
	typedef struct packed {
		logic [CountW-1:0] hold_time;
		logic [CountW-1:0] glitch_time;
		logic [TickW-1:0]  tick_period;
		logic [SpeedW-1:0] shutdown_speedup;
		logic              button_lock;
	} cfg_t;

	// Map the internal state onto the reported mode code.
	function automatic logic [ModeW-1:0] mode_code(input seq_state_t st);
		logic [ModeW-1:0] code;
		begin
			unique case (st)
				ST_UP_HOLD:     code = MODE_UP_HOLD;
				ST_UP_RELEASE:  code = MODE_UP_RELEASE;
				ST_LED_BLINK:   code = MODE_LED_BLINK;
				ST_GOOD_HOLD:   code = MODE_GOOD_HOLD;
				ST_RUN_RELEASE: code = MODE_RUN_RELEASE;
				ST_RUN_HOLD:    code = MODE_RUN_HOLD;
				default:        code = MODE_GOOD_HOLD;
			endcase
			return code;
		end
	endfunction

	// Countdown subtraction that clamps at zero.
	function automatic logic [CountW-1:0] sat_sub(input logic [CountW-1:0] a,
			input logic [CountW-1:0] b);
		begin
			return (a > b) ? (a - b) : '0;
		end
	endfunction

endpackage

FILE: rtl/pbs_if.sv
`timescale 1ns / 1ps

// Tick channel: one item per tick with the sampled button level.
interface pbs_tick_if;
	logic valid;
	logic ready;
	logic button_held;

	modport source (output valid, output button_held, input ready);
	modport sink   (input valid, input button_held, output ready);
endinterface

// Result channel: one item per accepted tick.
interface pbs_result_if;
	logic                      valid;
	logic                      ready;
	logic [pbs_pkg::ModeW-1:0] mode;
	logic                      blink_pulse;
	logic                      shutdown_request;
	logic                      shutdown_active;
	logic                      in_good_hold;

	modport source (output valid, output mode, output blink_pulse,
		output shutdown_request, output shutdown_active, output in_good_hold,
		input ready);
	modport sink   (input valid, input mode, input blink_pulse,
		input shutdown_request, input shutdown_active, input in_good_hold,
		output ready);
endinterface

FILE: rtl/power_button_sequencer_unit.sv
`timescale 1ns / 1ps

// Power-button sequencer.
// Each item on the tick channel is one periodic tick carrying the sampled
// button level. Every accepted item yields exactly one item on the result
// channel: the mode after the tick, the blink and shutdown-request pulses,
// the shutdown-active level and the good-hold flag.
// An item passes an input register and the sequencer logic into a result
// register. Its result is loaded into the result register when the item
// moves on from the input register, and can be taken from there. One item is
// accepted per cycle as long as the result channel keeps up; the state
// update is a single pass of short logic and limits nothing further.
// When the receiver stalls, the result register and the input register both
// hold, and tick.ready drops once both are full; nothing is lost.
// Reset puts the sequencer in power-up good hold with a countdown of 500,
// clears the shutdown flag and loads the register defaults (hold 500,
// glitch 100, tick 10, speedup 4, lock clear). The user is to write the APB
// registers only while idle; the block does not check it. pready stays high.
module power_button_sequencer_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [pbs_pkg::AddrW-1:0] paddr,
	input  logic [pbs_pkg::DataW-1:0] pwdata,
	output logic [pbs_pkg::DataW-1:0] prdata,
	output logic                      pready,
	pbs_tick_if.sink                  tick,
	pbs_result_if.source              result
);

	pbs_pkg::cfg_t cfg;

	pbs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pbs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.tick   (tick),
		.result (result)
	);

endmodule

FILE: rtl/pbs_cfg.sv
`timescale 1ns / 1ps

module pbs_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pbs_pkg::AddrW-1:0]  paddr,
	input  logic [pbs_pkg::DataW-1:0]  pwdata,
	output logic [pbs_pkg::DataW-1:0]  prdata,
	output logic                       pready,
	output pbs_pkg::cfg_t              cfg
);

	pbs_pkg::cfg_t    cfg_q;
	pbs_pkg::reg_idx_t idx;
	logic             wr_en;

	assign pready = 1'b1;
	assign idx    = pbs_pkg::reg_idx_t'(paddr[pbs_pkg::AddrW-1:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	// Register writes in the access phase; unmapped addresses are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_time        <= pbs_pkg::RstHoldTime;
			cfg_q.glitch_time      <= pbs_pkg::RstGlitchTime;
			cfg_q.tick_period      <= pbs_pkg::RstTickPeriod;
			cfg_q.shutdown_speedup <= pbs_pkg::RstSpeedup;
			cfg_q.button_lock      <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				pbs_pkg::REG_HOLD_TIME:   cfg_q.hold_time <= pwdata[pbs_pkg::CountW-1:0];
				pbs_pkg::REG_GLITCH_TIME: cfg_q.glitch_time <= pwdata[pbs_pkg::CountW-1:0];
				pbs_pkg::REG_TICK_PERIOD: cfg_q.tick_period <= pwdata[pbs_pkg::TickW-1:0];
				pbs_pkg::REG_SPEEDUP:     cfg_q.shutdown_speedup <= pwdata[pbs_pkg::SpeedW-1:0];
				pbs_pkg::REG_BUTTON_LOCK: cfg_q.button_lock <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back, zero-extended to the bus width.
	always_comb begin
		unique case (idx)
			pbs_pkg::REG_HOLD_TIME:   prdata = {16'd0, cfg_q.hold_time};
			pbs_pkg::REG_GLITCH_TIME: prdata = {16'd0, cfg_q.glitch_time};
			pbs_pkg::REG_TICK_PERIOD: prdata = {24'd0, cfg_q.tick_period};
			pbs_pkg::REG_SPEEDUP:     prdata = {28'd0, cfg_q.shutdown_speedup};
			pbs_pkg::REG_BUTTON_LOCK: prdata = {31'd0, cfg_q.button_lock};
			default:                  prdata = '0;
		endcase
	end

endmodule

FILE: rtl/pbs_core.sv
`timescale 1ns / 1ps

module pbs_core (
	input  logic          clk,
	input  logic          arst_n,
	input  pbs_pkg::cfg_t cfg,
	pbs_tick_if.sink      tick,
	pbs_result_if.source  result
);

	// Input stage.
	logic valid_s1;
	logic held_s1;
	logic advance;

	// Sequencer state.
	pbs_pkg::seq_state_t        state_q, state_d;
	logic [pbs_pkg::CountW-1:0] count_q, count_d;
	logic                       frozen_q, frozen_d;

	// Result register.
	logic                      out_valid_q;
	logic [pbs_pkg::ModeW-1:0] mode_q;
	logic                      blink_q, blink_d;
	logic                      request_q, request_d;
	logic                      active_q;
	logic                      good_q;

	logic [pbs_pkg::StepW-1:0]  run_step;
	logic [pbs_pkg::CountW-1:0] sub_base, sub_run;

	// The stage moves on when the result register is free or being emptied.
	assign advance    = valid_s1 & (~out_valid_q | result.ready);
	assign tick.ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			held_s1 <= tick.button_held;
		end
	end

	// Countdown steps: plain tick, and tick scaled by the speedup in run-held.
	assign run_step = cfg.tick_period * cfg.shutdown_speedup;
	assign sub_base = pbs_pkg::sat_sub(count_q,
		{{(pbs_pkg::CountW-pbs_pkg::TickW){1'b0}}, cfg.tick_period});
	assign sub_run  = pbs_pkg::sat_sub(count_q,
		{{(pbs_pkg::CountW-pbs_pkg::StepW){1'b0}}, run_step});

	// Next state for the item in the input stage.
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		frozen_d  = frozen_q;
		blink_d   = 1'b0;
		request_d = 1'b0;
		if (!frozen_q) begin
			unique case (state_q)
				pbs_pkg::ST_UP_HOLD: begin
					if (!held_s1) begin
						count_d = cfg.hold_time;
						state_d = pbs_pkg::ST_UP_RELEASE;
					end else if (sub_base == '0) begin
						state_d = pbs_pkg::ST_LED_BLINK;
						count_d = cfg.glitch_time;
					end else begin
						count_d = sub_base;
					end
				end
				pbs_pkg::ST_UP_RELEASE: begin
					if (held_s1) begin
						state_d = pbs_pkg::ST_UP_HOLD;
						count_d = cfg.hold_time;
					end else begin
						count_d = sub_base;
						if (sub_base == '0) begin
							frozen_d  = 1'b1;
							request_d = 1'b1;
						end
					end
				end
				pbs_pkg::ST_LED_BLINK, pbs_pkg::ST_GOOD_HOLD: begin
					// The blink state runs the good-hold logic on the same tick.
					blink_d = (state_q == pbs_pkg::ST_LED_BLINK);
					state_d = pbs_pkg::ST_GOOD_HOLD;
					if (held_s1) begin
						count_d = cfg.glitch_time;
					end else begin
						count_d = sub_base;
						if (sub_base == '0) begin
							state_d = pbs_pkg::ST_RUN_RELEASE;
						end
					end
				end
				pbs_pkg::ST_RUN_RELEASE: begin
					if (held_s1) begin
						state_d = pbs_pkg::ST_RUN_HOLD;
						count_d = cfg.hold_time;
					end
				end
				pbs_pkg::ST_RUN_HOLD: begin
					if (!held_s1) begin
						state_d = pbs_pkg::ST_RUN_RELEASE;
					end else begin
						count_d = sub_run;
						if (sub_run == '0 && !cfg.button_lock) begin
							frozen_d  = 1'b1;
							request_d = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// State and result valid update once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pbs_pkg::ST_GOOD_HOLD;
			count_q     <= pbs_pkg::RstHoldTime;
			frozen_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q  <= state_d;
				count_q  <= count_d;
				frozen_q <= frozen_d;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			mode_q    <= pbs_pkg::mode_code(state_d);
			blink_q   <= blink_d;
			request_q <= request_d;
			active_q  <= frozen_d;
			good_q    <= (state_d == pbs_pkg::ST_GOOD_HOLD);
		end
	end

	assign result.valid            = out_valid_q;
	assign result.mode             = mode_q;
	assign result.blink_pulse      = blink_q;
	assign result.shutdown_request = request_q;
	assign result.shutdown_active  = active_q;
	assign result.in_good_hold     = good_q;

endmodule
